/* rtl/drsq_pkg.sv */
// ----------------------------------------------------------------------------
// drsq_pkg
// shared types, codes and helpers of the drum reversing anti-crease sequencer
// ----------------------------------------------------------------------------
package drsq_pkg;

    localparam int unsigned TICK_PER_SECOND = 1000;
    localparam int unsigned TMR_W = $clog2(255 * TICK_PER_SECOND + 1);

    typedef logic [TMR_W-1:0] t_tmr;

    localparam logic [1:0] MS_STOPPED = 2'd0;
    localparam logic [1:0] MS_PAUSED  = 2'd1;
    localparam logic [1:0] MS_WORKING = 2'd2;

    localparam logic [1:0] SK_DRY    = 2'd1;
    localparam logic [1:0] SK_COOL   = 2'd2;
    localparam logic [1:0] SK_CREASE = 2'd3;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [1:0] RLY_FWD = 2'b01;
    localparam logic [1:0] RLY_REV = 2'b10;

    localparam logic [2:0] RP_IDLE  = 3'd0;
    localparam logic [2:0] RP_FWD   = 3'd1;
    localparam logic [2:0] RP_PAUSE = 3'd2;
    localparam logic [2:0] RP_REV   = 3'd3;
    localparam logic [2:0] RP_REST  = 3'd4;

    typedef enum logic [1:0] {
        TMR_STOPPED = 2'd0,
        TMR_RUNNING = 2'd1,
        TMR_PAUSED  = 2'd2
    } t_tmr_status;

    typedef enum logic [2:0] {
        CFG_DRY_TURN     = 3'd0,
        CFG_DRY_PAUSE    = 3'd1,
        CFG_COOL_TURN    = 3'd2,
        CFG_COOL_PAUSE   = 3'd3,
        CFG_CREASE_DELAY = 3'd4,
        CFG_CREASE_TURN  = 3'd5,
        CFG_CREASE_PAUSE = 3'd6,
        CFG_CREASE_LIMIT = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        CR_START    = 5'd0,
        CR_DELAY    = 5'd1,
        CR_KIND     = 5'd2,
        CR_COUNTED  = 5'd3,
        CR_CHECK    = 5'd4,
        CR_C_MODE   = 5'd5,
        CR_C1_GO    = 5'd6,
        CR_C1_TURN  = 5'd7,
        CR_C1_PAUSE = 5'd8,
        CR_C2_GO    = 5'd9,
        CR_C2_TF    = 5'd10,
        CR_C2_PF    = 5'd11,
        CR_C2_TR    = 5'd12,
        CR_C2_PR    = 5'd13,
        CR_ENDLESS  = 5'd14,
        CR_E1_GO    = 5'd15,
        CR_E1_TURN  = 5'd16,
        CR_E1_PAUSE = 5'd17,
        CR_E2_GO    = 5'd18,
        CR_E2_TF    = 5'd19,
        CR_E2_PF    = 5'd20,
        CR_E2_TR    = 5'd21,
        CR_E2_PR    = 5'd22,
        CR_WAIT     = 5'd23
    } t_crs_state;

    typedef struct packed {
        logic [1:0] machine_state;
        logic [1:0] step_kind;
        logic       test_mode;
        logic       crease_allowed;
        logic       dry_reverse_enable;
        logic       cool_reverse_enable;
        logic [6:0] speed_percent;
    } t_drsq_in;

    typedef struct packed {
        logic       forward_relay;
        logic       reverse_relay;
        logic [6:0] drive_speed;
        logic [1:0] direction_mark;
        logic       fan_request;
        logic       crease_done;
    } t_drsq_res;

    typedef struct packed {
        logic [7:0] delay_s;
        logic [6:0] turn_s;
        logic [6:0] pause_s;
        logic [4:0] limit;
    } t_crs_cfg;

    typedef struct packed {
        t_crs_state state;
        t_tmr       timer;
        logic [4:0] cycles;
        logic [1:0] relay;
        logic       fan;
        logic [6:0] speed;
    } t_crs_ctx;

    function automatic t_tmr ticks_of(input logic [7:0] seconds);
        ticks_of = TMR_W'(32'(seconds) * TICK_PER_SECOND);
    endfunction

endpackage

/* rtl/drsq_if.sv */
// ----------------------------------------------------------------------------
// drsq channel interfaces
// valid/ready channels for tick items, results and register writes
// ----------------------------------------------------------------------------
interface drsq_in_if;
    import drsq_pkg::*;
    logic     valid;
    logic     ready;
    t_drsq_in data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface drsq_res_if;
    import drsq_pkg::*;
    logic      valid;
    logic      ready;
    t_drsq_res data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface drsq_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/drsq_crease.sv */
// ----------------------------------------------------------------------------
// drsq_crease
// one tick of the anti-crease sequence: delay, counted or endless cycles
// ----------------------------------------------------------------------------
module drsq_crease (
    input  drsq_pkg::t_crs_cfg i_cfg,
    input  drsq_pkg::t_crs_ctx i_ctx,
    output drsq_pkg::t_crs_ctx o_ctx
);
    import drsq_pkg::*;

    t_crs_ctx c;
    t_tmr     turn_tmr;
    t_tmr     pause_tmr;

    assign turn_tmr  = ticks_of({1'b0, i_cfg.turn_s});
    assign pause_tmr = ticks_of({1'b0, i_cfg.pause_s});

    always_comb begin
        c = i_ctx;
        if (c.state == CR_START) begin
            c.cycles = i_cfg.limit;
            if (i_cfg.delay_s != 8'd0) begin
                c.timer = ticks_of(i_cfg.delay_s);
                c.relay = '0;
                c.speed = '0;
                c.state = CR_DELAY;
            end else begin
                c.state = CR_KIND;
            end
        end
        if (c.state == CR_DELAY && c.timer == '0) c.state = CR_KIND;
        if (c.state == CR_KIND) c.state = (i_cfg.limit == '0) ? CR_ENDLESS : CR_COUNTED;
        if (c.state == CR_COUNTED && i_cfg.limit != '0) c.state = CR_CHECK;
        if (c.state == CR_CHECK && i_cfg.limit != '0) begin
            c.state = (c.cycles == '0) ? CR_WAIT : CR_C_MODE;
        end
        if (c.state == CR_C_MODE) c.state = (i_cfg.pause_s == '0) ? CR_C1_GO : CR_C2_GO;
        // counted, no reversal
        if (c.state == CR_C1_GO) begin
            c.timer = turn_tmr;
            c.relay = c.relay | RLY_FWD;
            c.fan   = 1'b1;
            c.state = CR_C1_TURN;
        end
        if (c.state == CR_C1_TURN && c.timer == '0) begin
            c.relay = c.relay & ~RLY_FWD;
            c.fan   = 1'b0;
            c.timer = pause_tmr;
            c.state = CR_C1_PAUSE;
        end
        if (c.state == CR_C1_PAUSE && c.timer == '0) begin
            if (c.cycles != '0) c.cycles = c.cycles - 5'd1;
            c.state = CR_CHECK;
        end
        // counted with reversal
        if (c.state == CR_C2_GO) begin
            c.timer = turn_tmr;
            c.relay = c.relay | RLY_FWD;
            c.fan   = 1'b1;
            c.state = CR_C2_TF;
        end
        if (c.state == CR_C2_TF && c.timer == '0) begin
            c.relay = c.relay & ~RLY_FWD;
            c.timer = pause_tmr;
            c.state = CR_C2_PF;
        end
        if (c.state == CR_C2_PF && c.timer == '0) begin
            c.timer = turn_tmr;
            c.relay = c.relay | RLY_REV;
            c.fan   = 1'b1;
            c.state = CR_C2_TR;
        end
        if (c.state == CR_C2_TR && c.timer == '0) begin
            c.relay = c.relay & ~RLY_REV;
            c.fan   = 1'b0;
            c.timer = pause_tmr;
            c.state = CR_C2_PR;
        end
        if (c.state == CR_C2_PR && c.timer == '0) begin
            if (c.cycles != '0) c.cycles = c.cycles - 5'd1;
            c.state = CR_CHECK;
        end
        // endless
        if (c.state == CR_ENDLESS) c.state = (i_cfg.pause_s == '0) ? CR_E1_GO : CR_E2_GO;
        if (c.state == CR_E1_GO) begin
            c.timer = turn_tmr;
            c.relay = c.relay | RLY_FWD;
            c.fan   = 1'b1;
            c.state = CR_E1_TURN;
        end
        if (c.state == CR_E1_TURN && c.timer == '0) begin
            c.relay = c.relay & ~RLY_FWD;
            c.fan   = 1'b0;
            c.timer = pause_tmr;
            c.state = CR_E1_PAUSE;
        end
        if (c.state == CR_E1_PAUSE && c.timer == '0) c.state = CR_E1_GO;
        if (c.state == CR_E2_GO) begin
            c.timer = turn_tmr;
            c.relay = c.relay | RLY_FWD;
            c.fan   = 1'b1;
            c.state = CR_E2_TF;
        end
        if (c.state == CR_E2_TF && c.timer == '0) begin
            c.relay = c.relay & ~RLY_FWD;
            c.timer = pause_tmr;
            c.state = CR_E2_PF;
        end
        if (c.state == CR_E2_PF && c.timer == '0) begin
            c.timer = turn_tmr;
            c.relay = c.relay | RLY_REV;
            c.fan   = 1'b1;
            c.state = CR_E2_TR;
        end
        if (c.state == CR_E2_TR && c.timer == '0) begin
            c.relay = c.relay & ~RLY_REV;
            c.fan   = 1'b0;
            c.timer = pause_tmr;
            c.state = CR_E2_PR;
        end
        if (c.state == CR_E2_PR && c.timer == '0) c.state = CR_E2_GO;
    end

    assign o_ctx = c;

endmodule

/* rtl/drum_reversing_anticrease_sequencer_core.sv */
// ----------------------------------------------------------------------------
// drum_reversing_anticrease_sequencer_core
// dryer drum motor sequencer: reversing drying/cooling and anti-crease cycles
// ----------------------------------------------------------------------------
// channel   dir   transaction
// i_in      in    one millisecond tick with machine state, step and speed
// o_res     out   relay, speed, direction, fan and done flags for that tick
// i_cfg     in    register write, index 0..7, always ready
//
// one tick per clock while o_res takes results, state and result register updated in the accept cycle
// the result register frees on the same edge it is taken, so ticks stream
// a stall on o_res holds i_in.ready low until the result is taken
// reset is synchronous, registers other than the result data r_res take their reset values at a clock edge, not at once
// ----------------------------------------------------------------------------
module drum_reversing_anticrease_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drsq_in_if.sink    i_in,
    drsq_res_if.source o_res,
    drsq_cfg_if.sink   i_cfg
);
    import drsq_pkg::*;

    // configuration
    logic [7:0] r_dry_turn;
    logic [7:0] r_dry_pause;
    logic [7:0] r_cool_turn;
    logic [7:0] r_cool_pause;
    t_crs_cfg   r_crs_cfg;

    // sequencer state
    logic [2:0]  r_phase,  n_phase;
    t_tmr        r_pt,     n_pt;
    t_tmr_status r_st,     n_st;
    t_crs_state  r_crs,    n_crs;
    t_tmr        r_ct,     n_ct;
    logic [4:0]  r_cycles, n_cycles;
    logic [1:0]  r_relay,  n_relay;
    logic        r_fan,    n_fan;
    logic [1:0]  r_dir,    n_dir;
    logic [6:0]  r_speed,  n_speed;

    t_drsq_res r_res;
    logic      r_res_valid;

    logic       w_accept;
    t_tmr       w_pt_dec;
    t_tmr       w_ct_dec;
    t_crs_ctx   w_crs_in;
    t_crs_ctx   w_crs_out;
    logic       w_rev;
    logic [7:0] w_turn_s;
    logic [7:0] w_pause_s;
    t_drsq_in   w_in;

    assign w_in     = i_in.data;
    assign i_in.ready = !r_res_valid || o_res.ready;
    assign w_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign w_pt_dec = (r_st == TMR_RUNNING && r_pt != '0) ? r_pt - t_tmr'(1) : r_pt;
    assign w_ct_dec = (r_ct != '0) ? r_ct - t_tmr'(1) : r_ct;

    assign w_crs_in = '{state: r_crs, timer: w_ct_dec, cycles: r_cycles,
                        relay: r_relay, fan: r_fan, speed: w_in.speed_percent};

    drsq_crease u_crease (
        .i_cfg (r_crs_cfg),
        .i_ctx (w_crs_in),
        .o_ctx (w_crs_out)
    );

    assign w_rev     = (w_in.step_kind == SK_DRY) ? w_in.dry_reverse_enable
                                                  : w_in.cool_reverse_enable;
    assign w_turn_s  = (w_in.step_kind == SK_DRY) ? r_dry_turn  : r_cool_turn;
    assign w_pause_s = (w_in.step_kind == SK_DRY) ? r_dry_pause : r_cool_pause;

    always_comb begin
        n_phase  = r_phase;
        n_pt     = w_pt_dec;
        n_st     = r_st;
        n_crs    = r_crs;
        n_ct     = w_ct_dec;
        n_cycles = r_cycles;
        n_relay  = r_relay;
        n_fan    = r_fan;
        n_dir    = r_dir;
        n_speed  = r_speed;
        if (w_in.machine_state == MS_STOPPED || w_in.machine_state == MS_PAUSED) begin
            if (!w_in.test_mode) begin
                n_relay = '0;
                n_speed = '0;
            end
            if (w_in.machine_state == MS_STOPPED) begin
                n_dir    = DIR_IDLE;
                n_phase  = RP_IDLE;
                n_pt     = '0;
                n_st     = TMR_STOPPED;
                n_crs    = CR_START;
                n_ct     = '0;
                n_cycles = '0;
                n_fan    = 1'b0;
            end else if (r_st == TMR_RUNNING) begin
                n_st = TMR_PAUSED;
            end
        end else if (w_in.machine_state == MS_WORKING) begin
            n_speed = w_in.speed_percent;
            if (w_in.step_kind == SK_DRY || w_in.step_kind == SK_COOL) begin
                if (!w_rev) begin
                    n_dir   = DIR_FWD;
                    n_relay = r_relay | RLY_FWD;
                end else if (r_st == TMR_STOPPED || w_pt_dec == '0) begin
                    case (r_phase)
                        RP_FWD: begin
                            n_pt    = ticks_of(w_pause_s);
                            n_relay = '0;
                            n_speed = '0;
                            n_dir   = DIR_IDLE;
                            n_phase = RP_PAUSE;
                        end
                        RP_PAUSE: begin
                            n_pt    = ticks_of(w_turn_s);
                            n_dir   = DIR_REV;
                            n_relay = r_relay | RLY_REV;
                            n_phase = RP_REV;
                        end
                        RP_REV: begin
                            n_pt    = ticks_of(w_pause_s);
                            n_relay = '0;
                            n_speed = '0;
                            n_dir   = DIR_IDLE;
                            n_phase = RP_REST;
                        end
                        default: begin
                            n_pt    = ticks_of(w_turn_s);
                            n_dir   = DIR_FWD;
                            n_relay = r_relay | RLY_FWD;
                            n_phase = RP_FWD;
                        end
                    endcase
                    n_st = TMR_RUNNING;
                end else if (r_st == TMR_PAUSED) begin
                    if (r_phase == RP_PAUSE || r_phase == RP_REST) begin
                        n_relay = '0;
                        n_speed = '0;
                    end else if (r_phase == RP_REV) begin
                        n_dir   = DIR_REV;
                        n_relay = r_relay | RLY_REV;
                    end else begin
                        n_dir   = DIR_FWD;
                        n_relay = r_relay | RLY_FWD;
                        n_phase = RP_FWD;
                    end
                    n_st = TMR_RUNNING;
                end
            end else if (w_in.step_kind == SK_CREASE && w_in.crease_allowed
                         && !w_in.test_mode) begin
                n_crs    = w_crs_out.state;
                n_ct     = w_crs_out.timer;
                n_cycles = w_crs_out.cycles;
                n_relay  = w_crs_out.relay;
                n_fan    = w_crs_out.fan;
                n_speed  = w_crs_out.speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_turn        <= 8'd30;
            r_dry_pause       <= 8'd5;
            r_cool_turn       <= 8'd30;
            r_cool_pause      <= 8'd5;
            r_crs_cfg.delay_s <= 8'd0;
            r_crs_cfg.turn_s  <= 7'd10;
            r_crs_cfg.pause_s <= 7'd0;
            r_crs_cfg.limit   <= 5'd0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DRY_TURN:     r_dry_turn        <= i_cfg.data;
                CFG_DRY_PAUSE:    r_dry_pause       <= i_cfg.data;
                CFG_COOL_TURN:    r_cool_turn       <= i_cfg.data;
                CFG_COOL_PAUSE:   r_cool_pause      <= i_cfg.data;
                CFG_CREASE_DELAY: r_crs_cfg.delay_s <= i_cfg.data;
                CFG_CREASE_TURN:  r_crs_cfg.turn_s  <= i_cfg.data[6:0];
                CFG_CREASE_PAUSE: r_crs_cfg.pause_s <= i_cfg.data[6:0];
                CFG_CREASE_LIMIT: r_crs_cfg.limit   <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= RP_IDLE;
            r_pt     <= '0;
            r_st     <= TMR_STOPPED;
            r_crs    <= CR_START;
            r_ct     <= '0;
            r_cycles <= '0;
            r_relay  <= '0;
            r_fan    <= 1'b0;
            r_dir    <= DIR_IDLE;
            r_speed  <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_pt     <= n_pt;
            r_st     <= n_st;
            r_crs    <= n_crs;
            r_ct     <= n_ct;
            r_cycles <= n_cycles;
            r_relay  <= n_relay;
            r_fan    <= n_fan;
            r_dir    <= n_dir;
            r_speed  <= n_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res.forward_relay  <= n_relay[0];
            r_res.reverse_relay  <= n_relay[1];
            r_res.drive_speed    <= n_speed;
            r_res.direction_mark <= n_dir;
            r_res.fan_request    <= n_fan;
            r_res.crease_done    <= (n_crs == CR_WAIT);
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

endmodule
